// ===== rtl/tfb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants of the temporal frame blend unit: half-sine
// frame weights in Q1.15, accumulator widths and the reciprocal of the
// weight total used for the final divide.
// ----------------------------------------------------------------------------
package tfb_pkg;

    localparam int CHAN_W          = 8;
    localparam int NUM_CH          = 3;
    localparam int CFG_W           = 19;
    localparam int POS_W           = 18;
    localparam int SUM_W           = 27;
    localparam int WEIGHT_W        = 16;
    localparam int TOTAL_W         = 19;
    localparam int FRAMES_PER_GROUP = 16;
    localparam int GROUP_W         = 4;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [CFG_W-1:0]   FRAME_PIXELS_RESET = 19'd262144;
    localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE       = 8'hFF;
    localparam logic [GROUP_W-1:0] FIRST_FRAME        = GROUP_W'(0);
    localparam logic [GROUP_W-1:0] LAST_FRAME         = GROUP_W'(FRAMES_PER_GROUP - 1);

    // round(2^15 * sin(pi*k/15)), end weights zero
    localparam logic [WEIGHT_W-1:0] WEIGHTS [FRAMES_PER_GROUP] = '{
        16'd0,     16'd6813,  16'd13328, 16'd19261,
        16'd24351, 16'd28378, 16'd31164, 16'd32588,
        16'd32588, 16'd31164, 16'd28378, 16'd24351,
        16'd19261, 16'd13328, 16'd6813,  16'd0
    };

    localparam logic [TOTAL_W-1:0] WEIGHT_TOTAL = 19'd311766;

    // floor(2^45 / total): quotient estimate is low by at most one
    localparam int          RECIP_SHIFT = 45;
    localparam int          RECIP_W     = 27;
    localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'(WEIGHT_TOTAL);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam int          QUOT_W      = SUM_W + RECIP_W - RECIP_SHIFT;

    typedef logic [NUM_CH-1:0][SUM_W-1:0]  sum_vec_t;
    typedef logic [NUM_CH-1:0][CHAN_W-1:0] chan_vec_t;

    typedef struct packed {
        sum_vec_t         sum;
        logic [POS_W-1:0] pos;
        logic             frame_end;
    } blend_req_t;

endpackage
`default_nettype wire

// ===== rtl/tfb_accum.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_accum
// Pixel and frame counters and the per-pixel accumulator memory. Each beat
// reads its entry, adds weight times channel (frame 0 overwrites), and
// writes back; the last write is forwarded to a read of the same entry.
// ----------------------------------------------------------------------------
module tfb_accum #(
    parameter int MAX_PIXELS = 262144
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [tfb_pkg::CFG_W-1:0]   frame_pixels,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  red_in,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  green_in,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  blue_in,
    output logic                             req_valid,
    input  wire logic                        req_ready,
    output tfb_pkg::blend_req_t              req
);
    import tfb_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CMP_W  = ((ADDR_W > CFG_W) ? ADDR_W : CFG_W) + 1;
    localparam int PROD_W = WEIGHT_W + CHAN_W;

    sum_vec_t acc_mem [MAX_PIXELS];

    logic [ADDR_W-1:0]  pixel_cnt_reg;
    logic [ADDR_W-1:0]  pixel_cnt_next;
    logic [GROUP_W-1:0] frame_cnt_reg;
    logic [GROUP_W-1:0] frame_cnt_next;

    logic               s1_valid_reg;
    chan_vec_t          s1_chan_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [GROUP_W-1:0] s1_k_reg;
    logic               s1_last_reg;

    sum_vec_t           rd_data_reg;
    sum_vec_t           fwd_data_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic               fwd_valid_reg;

    logic [CMP_W-1:0]   fp_ext;
    logic [CMP_W-1:0]   max_ext;
    logic [CMP_W-1:0]   size;
    logic               last_pixel;
    logic               accept;
    logic               s1_emit;
    logic               s1_go;
    sum_vec_t           base;
    sum_vec_t           sum_next;
    logic [NUM_CH-1:0][PROD_W-1:0] prod;

    assign accept  = in_valid && in_ready;
    assign s1_emit = (s1_k_reg == LAST_FRAME);
    assign s1_go   = s1_valid_reg && (!s1_emit || req_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    assign fp_ext  = CMP_W'(frame_pixels);
    assign max_ext = CMP_W'(MAX_PIXELS);

    always_comb
    begin
        if (fp_ext == '0)
        begin
            size = CMP_W'(1);
        end
        else if (fp_ext > max_ext)
        begin
            size = max_ext;
        end
        else
        begin
            size = fp_ext;
        end
        last_pixel = (CMP_W'(pixel_cnt_reg) + CMP_W'(1)) >= size;
        if (last_pixel)
        begin
            pixel_cnt_next = '0;
            frame_cnt_next = (frame_cnt_reg == LAST_FRAME) ? FIRST_FRAME
                                                           : frame_cnt_reg + GROUP_W'(1);
        end
        else
        begin
            pixel_cnt_next = pixel_cnt_reg + ADDR_W'(1);
            frame_cnt_next = frame_cnt_reg;
        end
    end

    always_comb
    begin
        if (s1_k_reg == FIRST_FRAME)
        begin
            base = '0;
        end
        else if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            base = fwd_data_reg;
        end
        else
        begin
            base = rd_data_reg;
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod[c]     = PROD_W'(WEIGHTS[s1_k_reg]) * PROD_W'(s1_chan_reg[c]);
            sum_next[c] = base[c] + SUM_W'(prod[c]);
        end
    end

    assign req_valid     = s1_valid_reg && s1_emit;
    assign req.sum       = sum_next;
    assign req.pos       = POS_W'(s1_addr_reg);
    assign req.frame_end = s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pixel_cnt_reg <= '0;
            frame_cnt_reg <= FIRST_FRAME;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                pixel_cnt_reg <= pixel_cnt_next;
                frame_cnt_reg <= frame_cnt_next;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_chan_reg[CH_RED]   <= red_in;
            s1_chan_reg[CH_GREEN] <= green_in;
            s1_chan_reg[CH_BLUE]  <= blue_in;
            s1_addr_reg           <= pixel_cnt_reg;
            s1_k_reg              <= frame_cnt_reg;
            s1_last_reg           <= last_pixel;
        end
        if (s1_go)
        begin
            fwd_data_reg <= sum_next;
            fwd_addr_reg <= s1_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= acc_mem[pixel_cnt_reg];
        end
        if (s1_go)
        begin
            acc_mem[s1_addr_reg] <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tfb_divide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_divide
// Divides the three accumulated sums by the weight total: the request is
// registered, a reciprocal multiply gives a quotient at most one low, then
// one compare corrects it. Ends in the output register.
// ----------------------------------------------------------------------------
module tfb_divide (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire tfb_pkg::blend_req_t         req,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tfb_pkg::CHAN_W-1:0]       red_out,
    output logic [tfb_pkg::CHAN_W-1:0]       green_out,
    output logic [tfb_pkg::CHAN_W-1:0]       blue_out,
    output logic [tfb_pkg::CHAN_W-1:0]       alpha_out,
    output logic [tfb_pkg::POS_W-1:0]        pixel_position,
    output logic                             frame_end
);
    import tfb_pkg::*;

    localparam int RP_W = SUM_W + RECIP_W;
    localparam int BP_W = QUOT_W + TOTAL_W;

    logic [NUM_CH-1:0][RP_W-1:0]   recip_prod;
    logic [NUM_CH-1:0][QUOT_W-1:0] quot_next;
    logic [NUM_CH-1:0][BP_W-1:0]   back_prod;
    logic [NUM_CH-1:0][SUM_W-1:0]  rem;
    logic [NUM_CH-1:0][QUOT_W-1:0] quot_fix;
    chan_vec_t                     chan_next;

    logic                          hold_valid_reg;
    blend_req_t                    hold_req_reg;

    logic                          s2_valid_reg;
    logic [NUM_CH-1:0][QUOT_W-1:0] s2_quot_reg;
    sum_vec_t                      s2_sum_reg;
    logic [POS_W-1:0]              s2_pos_reg;
    logic                          s2_end_reg;

    logic                          out_valid_reg;
    chan_vec_t                     chan_out_reg;
    logic [POS_W-1:0]              pos_out_reg;
    logic                          end_out_reg;

    logic                          s2_go;
    logic                          s2_load;
    logic                          req_load;

    assign s2_go     = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_load   = hold_valid_reg && (!s2_valid_reg || s2_go);
    assign req_ready = !hold_valid_reg || s2_load;
    assign req_load  = req_valid && req_ready;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            recip_prod[c] = RP_W'(hold_req_reg.sum[c]) * RP_W'(RECIP);
            quot_next[c]  = recip_prod[c][RP_W-1:RECIP_SHIFT];
            back_prod[c]  = BP_W'(s2_quot_reg[c]) * BP_W'(WEIGHT_TOTAL);
            rem[c]        = s2_sum_reg[c] - SUM_W'(back_prod[c]);
            quot_fix[c]   = s2_quot_reg[c] + QUOT_W'(rem[c] >= SUM_W'(WEIGHT_TOTAL));
            chan_next[c]  = quot_fix[c][CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_load)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (s2_load)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            hold_req_reg <= req;
        end
        if (s2_load)
        begin
            s2_quot_reg <= quot_next;
            s2_sum_reg  <= hold_req_reg.sum;
            s2_pos_reg  <= hold_req_reg.pos;
            s2_end_reg  <= hold_req_reg.frame_end;
        end
        if (s2_go)
        begin
            chan_out_reg <= chan_next;
            pos_out_reg  <= s2_pos_reg;
            end_out_reg  <= s2_end_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign red_out        = chan_out_reg[CH_RED];
    assign green_out      = chan_out_reg[CH_GREEN];
    assign blue_out       = chan_out_reg[CH_BLUE];
    assign alpha_out      = ALPHA_OPAQUE;
    assign pixel_position = pos_out_reg;
    assign frame_end      = end_out_reg;

endmodule
`default_nettype wire

// ===== rtl/temporal_frame_blend_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// temporal_frame_blend_unit
// Blends groups of 16 RGB frames with half-sine weights into one frame and
// streams the blended pixels out during the last frame of each group.
// ----------------------------------------------------------------------------
//  Port group   Handshake              Beat carries
//  in           in_valid / in_ready    red_in, green_in, blue_in
//  out          out_valid / out_ready  red/green/blue/alpha_out, pixel_position, frame_end
//  cfg          cfg_valid / cfg_ready  cfg_data (pixels per frame)
//
//  One pixel per cycle sustained while out_ready does not stall, set by the
//  accumulator memory: one read and one write each cycle, the previous write
//  forwarded to a read of its entry. A beat goes through the stage-1 accumulate, the
//  request hold, the reciprocal multiply and the correction into the output register.
//  Reset needs no clearing pass; frame 0 of each group overwrites its entries.
//  A held out_ready backs the stages up to in_ready; cfg_ready is always high.
// ----------------------------------------------------------------------------
module temporal_frame_blend_unit #(
    parameter int MAX_PIXELS = 262144
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  red_in,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  green_in,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  blue_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tfb_pkg::CHAN_W-1:0]       red_out,
    output logic [tfb_pkg::CHAN_W-1:0]       green_out,
    output logic [tfb_pkg::CHAN_W-1:0]       blue_out,
    output logic [tfb_pkg::CHAN_W-1:0]       alpha_out,
    output logic [tfb_pkg::POS_W-1:0]        pixel_position,
    output logic                             frame_end,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tfb_pkg::CFG_W-1:0]   cfg_data
);
    import tfb_pkg::*;

    logic [CFG_W-1:0] frame_pixels_reg;
    logic             req_valid;
    logic             req_ready;
    blend_req_t       req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_pixels_reg <= cfg_data;
        end
    end

    tfb_accum #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_pixels (frame_pixels_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req)
    );

    tfb_divide u_divide (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .alpha_out      (alpha_out),
        .pixel_position (pixel_position),
        .frame_end      (frame_end)
    );

endmodule
`default_nettype wire

// ===== rtl/tfb_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_checker
// Port-level checks of the temporal frame blend unit: output hold under
// stall, opaque alpha, and the raster order of emitted pixels.
// ----------------------------------------------------------------------------
module tfb_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        out_valid,
    input  wire logic                        out_ready,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  red_out,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  green_out,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  blue_out,
    input  wire logic [tfb_pkg::CHAN_W-1:0]  alpha_out,
    input  wire logic [tfb_pkg::POS_W-1:0]   pixel_position,
    input  wire logic                        frame_end
);
    import tfb_pkg::*;

    logic             seen_reg;
    logic             end_prev_reg;
    logic [POS_W-1:0] pos_prev_reg;
    logic             out_beat;

    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            end_prev_reg <= 1'b0;
            pos_prev_reg <= '0;
        end
        else if (out_beat)
        begin
            seen_reg     <= 1'b1;
            end_prev_reg <= frame_end;
            pos_prev_reg <= pixel_position;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(pixel_position) && $stable(frame_end))
        else $error("output beat changed while stalled");

    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alpha_out == ALPHA_OPAQUE)
        else $error("alpha not opaque");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && seen_reg && end_prev_reg |-> pixel_position == '0)
        else $error("output frame did not restart at pixel zero");

    a_raster_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && seen_reg && !end_prev_reg
            |-> pixel_position == POS_W'(pos_prev_reg + POS_W'(1)))
        else $error("output pixel skipped or repeated");

endmodule

bind temporal_frame_blend_unit tfb_checker u_tfb_checker (.*);
`default_nettype wire

// ===== test/frame_blend_checker.sv =====
// ----------------------------------------------------------------------------
// frame_blend_checker
// Watches the pixel, blend and frame size channels of the temporal frame
// blend unit. Every accepted pixel beat runs through an own model of the
// half-sine weighted accumulation; each blended pixel it yields is queued and
// compared field by field with the next output beat.
// ----------------------------------------------------------------------------
module frame_blend_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [tfb_pkg::CHAN_W-1:0] red_in,
    input  logic [tfb_pkg::CHAN_W-1:0] green_in,
    input  logic [tfb_pkg::CHAN_W-1:0] blue_in,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [tfb_pkg::CHAN_W-1:0] red_out,
    input  logic [tfb_pkg::CHAN_W-1:0] green_out,
    input  logic [tfb_pkg::CHAN_W-1:0] blue_out,
    input  logic [tfb_pkg::CHAN_W-1:0] alpha_out,
    input  logic [tfb_pkg::POS_W-1:0]  pixel_position,
    input  logic                       frame_end,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [tfb_pkg::CFG_W-1:0]  cfg_data,
    output int                         fail_count,
    output int                         blends_pending,
    output int                         blends_checked
);
    import tfb_pkg::*;

    localparam int                GROUP_FRAMES = 16;
    localparam int                FRAC_BITS    = 15;
    localparam int                MAX_FRAME    = 262144;
    localparam longint unsigned   PI_FIX       = 64'd3373259426;
    localparam logic [CHAN_W-1:0] OPAQUE       = 8'hFF;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic [POS_W-1:0]  pos;
        logic              last;
    } blend_pixel_t;

    longint unsigned  frame_weight [GROUP_FRAMES];
    longint unsigned  weight_sum;
    longint unsigned  red_acc [MAX_FRAME];
    longint unsigned  green_acc [MAX_FRAME];
    longint unsigned  blue_acc [MAX_FRAME];
    int               pix_idx;
    int               grp_frame;
    int               mismatches;
    int               matched;
    logic [CFG_W-1:0] frame_cfg;
    blend_pixel_t     blend_q [$];
    blend_pixel_t     want;

    // sin(pi*m/den) in Q2.30 for 2*m <= den
    function automatic longint unsigned half_sine_q30(longint unsigned m, longint unsigned den);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned acc;
        longint unsigned term;
        longint unsigned n;
        x = (PI_FIX * m * 2 + den) / (2 * den);
        x2 = (x * x) >> 30;
        acc = x;
        term = x;
        for (n = 1; n <= 12; n++)
        begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n[0])
                acc = acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    initial
    begin
        int k;
        weight_sum = 0;
        for (k = 0; k < GROUP_FRAMES; k++)
        begin
            frame_weight[k] = (half_sine_q30((k <= GROUP_FRAMES - 1 - k) ? k : GROUP_FRAMES - 1 - k,
                                             GROUP_FRAMES - 1)
                               + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            weight_sum += frame_weight[k];
        end
    end

    function automatic void blend_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                        logic [CHAN_W-1:0] b);
        int              span;
        int              addr;
        int              k;
        bit              last;
        longint unsigned w;
        blend_pixel_t    res;
        span = (frame_cfg == 0) ? 1 : ((frame_cfg > MAX_FRAME) ? MAX_FRAME : int'(frame_cfg));
        addr = (pix_idx >= MAX_FRAME) ? MAX_FRAME - 1 : pix_idx;
        k = (grp_frame >= GROUP_FRAMES) ? 0 : grp_frame;
        w = frame_weight[k];
        if (k == 0)
        begin
            red_acc[addr]   = w * r;
            green_acc[addr] = w * g;
            blue_acc[addr]  = w * b;
        end
        else
        begin
            red_acc[addr]   += w * r;
            green_acc[addr] += w * g;
            blue_acc[addr]  += w * b;
        end
        last = (pix_idx + 1 >= span);
        if (k == GROUP_FRAMES - 1)
        begin
            res.red   = CHAN_W'(red_acc[addr] / weight_sum);
            res.green = CHAN_W'(green_acc[addr] / weight_sum);
            res.blue  = CHAN_W'(blue_acc[addr] / weight_sum);
            res.alpha = OPAQUE;
            res.pos   = POS_W'(pix_idx);
            res.last  = last;
            blend_q = {blend_q, res};
        end
        if (last)
        begin
            pix_idx = 0;
            grp_frame = (k + 1 >= GROUP_FRAMES) ? 0 : k + 1;
        end
        else
        begin
            pix_idx = pix_idx + 1;
            grp_frame = k;
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_idx = 0;
            grp_frame = 0;
            frame_cfg = FRAME_PIXELS_RESET;
            blend_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frame_cfg = cfg_data;
            if (out_valid && out_ready)
            begin
                if (blend_q.size() == 0)
                begin
                    $error("blended pixel at position %0d with none predicted", pixel_position);
                    mismatches++;
                end
                else
                begin
                    want = blend_q.pop_front();
                    check_field("red_out", want.red, red_out);
                    check_field("green_out", want.green, green_out);
                    check_field("blue_out", want.blue, blue_out);
                    check_field("alpha_out", want.alpha, alpha_out);
                    check_field("pixel_position", want.pos, pixel_position);
                    check_field("frame_end", want.last, frame_end);
                    matched++;
                end
            end
            if (in_valid && in_ready)
                blend_pixel(red_in, green_in, blue_in);
        end
        fail_count     <= mismatches;
        blends_pending <= blend_q.size();
        blends_checked <= matched;
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams RGB pixel beats through the temporal frame blend unit in groups of
// sixteen frames at many frame sizes, with random gaps on both channels, and
// lets frame_blend_checker predict and compare every blended pixel.
// ----------------------------------------------------------------------------
module testbench;
    import tfb_pkg::*;

    localparam int PIXEL_TARGET  = 950;
    localparam int BLEND_TARGET  = 48;
    localparam int GROUP_FRAMES  = 16;
    localparam int MAX_FRAME     = 262144;
    localparam int MAX_GAP       = 16;
    localparam int SETTLE_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic              out_valid;
    logic              out_ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic [POS_W-1:0]  pixel_position;
    logic              frame_end;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    int fail_count;
    int blends_pending;
    int blends_checked;

    bit in_fast;
    bit out_fast;
    int frame_size;
    int frame_pixel;
    int group_frame;
    int frame0_written;
    int pixels_sent;
    int blends_due;
    int size_writes;
    int size_min;
    int size_max;

    temporal_frame_blend_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .alpha_out      (alpha_out),
        .pixel_position (pixel_position),
        .frame_end      (frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    frame_blend_checker blend_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .alpha_out      (alpha_out),
        .pixel_position (pixel_position),
        .frame_end      (frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .blends_pending (blends_pending),
        .blends_checked (blends_checked)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [CHAN_W-1:0] draw_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
        int gap;
        gap = in_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pixels_sent++;
        if (group_frame == GROUP_FRAMES - 1)
            blends_due++;
        if (group_frame == 0 && frame_pixel + 1 > frame0_written)
            frame0_written = frame_pixel + 1;
        if (frame_pixel + 1 >= frame_size) begin
            frame_pixel = 0;
            group_frame = (group_frame + 1) % GROUP_FRAMES;
            if (group_frame == 0)
                frame0_written = 0;
        end else begin
            frame_pixel++;
        end
    endtask

    // hold input, wait out every predicted blend and the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (blends_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frame_pixels(logic [CFG_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        frame_size = (value == 0) ? 1 : ((value > MAX_FRAME) ? MAX_FRAME : int'(value));
        size_writes++;
        if (frame_size < size_min)
            size_min = frame_size;
        if (frame_size > size_max)
            size_max = frame_size;
    endtask

    initial begin
        int stall;
        out_ready <= 1'b0;
        out_fast = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 23) == 0)
                out_fast = !out_fast;
            stall = out_fast ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        int k;
        int v;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        red_in    <= '0;
        green_in  <= '0;
        blue_in   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_fast = 1'b0;
        frame_size = MAX_FRAME;
        frame_pixel = 0;
        group_frame = 0;
        frame0_written = 0;
        pixels_sent = 0;
        blends_due = 0;
        size_writes = 0;
        size_min = MAX_FRAME;
        size_max = MAX_FRAME;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // oversized and zero sizes inside frame 0, the last one ends it early
        send_pixel('1, '1, '1);
        send_pixel('0, '0, '0);
        write_frame_pixels(FRAME_PIXELS_RESET);
        send_pixel('1, '0, 8'hAA);
        write_frame_pixels('1);
        send_pixel('0, '1, 8'h55);
        write_frame_pixels('0);
        send_pixel('1, '1, '1);
        for (k = 1; k < GROUP_FRAMES; k++)
            send_pixel('1, '0, CHAN_W'(k * 17));

        while (pixels_sent < PIXEL_TARGET || blends_due < BLEND_TARGET) begin
            in_fast = ($urandom_range(0, 3) == 0);
            if ((group_frame == 0 && frame_pixel == 0) ? ($urandom_range(0, 3) != 0)
                                                       : ($urandom_range(0, 9) == 0)) begin
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = $urandom_range(9, 40);
                    default: v = $urandom_range(2, 8);
                endcase
                // past frame 0, never grow beyond the entries frame 0 wrote
                if (group_frame != 0 && v > frame0_written)
                    v = $urandom_range(0, frame0_written);
                write_frame_pixels(CFG_W'(v));
            end
            if ($urandom_range(0, 3) != 0) begin
                do
                    send_pixel(draw_channel(), draw_channel(), draw_channel());
                while (group_frame != 0 || frame_pixel != 0);
            end else begin
                repeat ($urandom_range(1, 40))
                    send_pixel(draw_channel(), draw_channel(), draw_channel());
            end
        end

        settle();
        $display("Sent %0d pixel beats over frame sizes %0d to %0d with %0d size writes",
                 pixels_sent, size_min, size_max, size_writes);
        $display("Compared %0d blended pixels", blends_checked);
        if (fail_count == 0 && blends_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #10_000_000;
        $error("timed out with %0d blended pixels outstanding", blends_pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tfb_pkg.sv
rtl/tfb_accum.sv
rtl/tfb_divide.sv
rtl/temporal_frame_blend_unit.sv
rtl/tfb_checker.sv
test/frame_blend_checker.sv
test/testbench.sv
